// ===== hw/rtl/tpss_pkg.sv =====
// Package with shared constants and word types for the triangle plane slicer.
`timescale 1ns / 1ps
package tpss_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int DIV_STAGES = 16;
  localparam int LERP_LAT = DIV_STAGES + 3;
  localparam int OUT_LAT = LERP_LAT + 4;

  typedef struct packed {
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_a_z;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_b_z;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic signed [31:0] vert_c_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
  } seg_t;

endpackage

// ===== hw/rtl/tpss_lerp.sv =====
// Pipelined edge crossing unit: multiply, restoring divide two bits a stage, round.
`timescale 1ns / 1ps
module tpss_lerp (
  input  logic               clk,
  input  logic signed [31:0] u,
  input  logic signed [31:0] v,
  input  logic signed [31:0] uz,
  input  logic signed [31:0] vz,
  input  logic signed [31:0] level,
  output logic signed [31:0] res
);
  import tpss_pkg::*;

  function automatic logic [32:0] divstep(input logic [31:0] r, input logic b,
                                          input logic [31:0] d);
    logic [32:0] rs;
    logic [32:0] df;
    rs = {r, b};
    df = rs - {1'b0, d};
    if (rs >= {1'b0, d}) begin
      return {1'b1, df[31:0]};
    end
    return {1'b0, rs[31:0]};
  endfunction

  logic signed [32:0] du, num, den;
  logic [31:0] a_du, a_num, a_den;
  logic a_neg;
  logic signed [31:0] a_v;
  logic [63:0] prod;
  logic [31:0] b_den;
  logic b_neg;
  logic signed [31:0] b_v;

  logic [31:0] r_s [0:DIV_STAGES];
  logic [31:0] lo_s [0:DIV_STAGES];
  logic [31:0] q_s [0:DIV_STAGES];
  logic [31:0] d_s [0:DIV_STAGES];
  logic neg_s [0:DIV_STAGES];
  logic signed [31:0] v_s [0:DIV_STAGES];

  logic [31:0] rd;
  logic [32:0] qr;
  logic signed [33:0] sum;

  assign du  = 33'(u) - 33'(v);
  assign num = 33'(level) - 33'(vz);
  assign den = 33'(uz) - 33'(vz);

  always_ff @(posedge clk) begin
    a_du  <= du[32] ? 32'(-du) : du[31:0];
    a_num <= num[32] ? 32'(-num) : num[31:0];
    a_den <= den[32] ? 32'(-den) : den[31:0];
    a_neg <= du[32] ^ num[32] ^ den[32];
    a_v   <= v;
    prod  <= 64'(a_du) * 64'(a_num);
    b_den <= a_den;
    b_neg <= a_neg;
    b_v   <= a_v;
  end

  assign r_s[0]   = prod[63:32];
  assign lo_s[0]  = prod[31:0];
  assign q_s[0]   = '0;
  assign d_s[0]   = b_den;
  assign neg_s[0] = b_neg;
  assign v_s[0]   = b_v;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] t0, t1;
    assign t0 = divstep(r_s[k], lo_s[k][31], d_s[k]);
    assign t1 = divstep(t0[31:0], lo_s[k][30], d_s[k]);
    always_ff @(posedge clk) begin
      r_s[k+1]   <= t1[31:0];
      lo_s[k+1]  <= {lo_s[k][29:0], 2'b00};
      q_s[k+1]   <= {q_s[k][29:0], t0[32], t1[32]};
      d_s[k+1]   <= d_s[k];
      neg_s[k+1] <= neg_s[k];
      v_s[k+1]   <= v_s[k];
    end
  end

  assign rd  = d_s[DIV_STAGES] - r_s[DIV_STAGES];
  assign qr  = {1'b0, q_s[DIV_STAGES]} + 33'(r_s[DIV_STAGES] >= rd);
  assign sum = neg_s[DIV_STAGES] ? 34'(v_s[DIV_STAGES]) - 34'(qr)
                                 : 34'(v_s[DIV_STAGES]) + 34'(qr);

  always_ff @(posedge clk) begin
    res <= sum[31:0];
  end

endmodule

// ===== hw/rtl/triangle_plane_slice_segment.sv =====
// Top level of the triangle plane slicer: facet classification, crossings, orientation.
//
//   channel  handshake        payload  direction
//   facet    start / busy     item     in
//   segment  done (strobe)    result   out
//   level    cfg_we           cfg_data in
//
// One facet is taken every cycle; busy stays low. A segment passes from its facet through
// the input registers, the crossing units with their 16 stage divider and the output registers.
// Reset clears the valid bits and sets the level to zero. The receiver
// cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module triangle_plane_slice_segment (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tpss_pkg::item_t      item,
  input  logic                 cfg_we,
  input  logic signed [31:0]   cfg_data,
  output logic                 done,
  output tpss_pkg::seg_t       result
);
  import tpss_pkg::*;

  localparam int SHORT_LIM = (1 << COORD_FRAC_BITS) / 1000 + 1;
  localparam int SW = $clog2(SHORT_LIM + 1);
  localparam int NEAR_K = 100000;

  typedef enum logic [2:0] {SRC_V0, SRC_V1, SRC_V2, SRC_L01, SRC_L12, SRC_L20} src_t;

  typedef struct packed {
    logic keep;
    logic on_edge;
    src_t p1s;
    src_t p2s;
    logic signed [31:0] x0, y0, x1, y1, x2, y2;
    logic nxn, nxp, nyn, nyp;
  } side_t;

  logic signed [31:0] level;
  item_t it;
  logic signed [31:0] lvl;
  logic v0;
  side_t side_next;
  side_t side [1:LERP_LAT];
  logic vld [1:LERP_LAT];
  logic signed [31:0] l01x, l01y, l12x, l12y, l20x, l20y;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      v0 <= 1'b0;
    end else begin
      if (cfg_we) begin
        level <= cfg_data;
      end
      v0 <= start;
    end
    it  <= item;
    lvl <= level;
  end

  always_comb begin
    logic signed [31:0] z0, z1, z2;
    logic b01, b12, b20, t1, t2, on_e, rej;
    z0 = it.vert_a_z;
    z1 = it.vert_b_z;
    z2 = it.vert_c_z;
    b01 = (z0 <= lvl && lvl <= z1) || (z1 <= lvl && lvl <= z0);
    b12 = (z1 <= lvl && lvl <= z2) || (z2 <= lvl && lvl <= z1);
    b20 = (z2 <= lvl && lvl <= z0) || (z0 <= lvl && lvl <= z2);
    t1 = 1'b0;
    t2 = 1'b0;
    on_e = 1'b0;
    rej = 1'b0;
    side_next = '0;
    side_next.p1s = SRC_L01;
    side_next.p2s = SRC_L20;
    if ((lvl < z0 && lvl < z1 && lvl < z2) || (z0 < lvl && z1 < lvl && z2 < lvl)) begin
      rej = 1'b1;
    end
    if (z0 == lvl && z1 == lvl && z2 == lvl) begin
      rej = 1'b1;
    end
    if ((z0 == lvl && z1 == lvl && z2 < lvl) || (z0 == lvl && z2 == lvl && z1 < lvl) ||
        (z1 == lvl && z2 == lvl && z0 < lvl)) begin
      rej = 1'b1;
    end
    if (b01) begin
      if (z0 == z1) begin
        if (it.vert_c_y > lvl) begin
          rej = 1'b1;
        end
        side_next.p1s = SRC_V0;
        side_next.p2s = SRC_V1;
        on_e = 1'b1;
      end else begin
        side_next.p1s = SRC_L01;
        t1 = 1'b1;
      end
    end
    if (!on_e && b12) begin
      if (z1 == z2) begin
        if (it.vert_a_y > lvl) begin
          rej = 1'b1;
        end
        side_next.p1s = SRC_V1;
        side_next.p2s = SRC_V2;
        on_e = 1'b1;
      end else if (!t1) begin
        side_next.p1s = SRC_L12;
        t1 = 1'b1;
      end else begin
        side_next.p2s = SRC_L12;
        t2 = 1'b1;
      end
    end
    if (!on_e) begin
      if (!t1) begin
        rej = 1'b1;
      end
      if (!t2 && b20) begin
        side_next.p2s = SRC_L20;
        t2 = 1'b1;
      end
      if (!t2) begin
        rej = 1'b1;
      end
    end
    side_next.keep = !rej;
    side_next.on_edge = on_e;
    side_next.x0 = it.vert_a_x;
    side_next.y0 = it.vert_a_y;
    side_next.x1 = it.vert_b_x;
    side_next.y1 = it.vert_b_y;
    side_next.x2 = it.vert_c_x;
    side_next.y2 = it.vert_c_y;
    side_next.nxn = it.normal_x < 0;
    side_next.nxp = it.normal_x > 0;
    side_next.nyn = it.normal_y < 0;
    side_next.nyp = it.normal_y > 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LERP_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[1] <= v0;
      for (int k = 2; k <= LERP_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
    side[1] <= side_next;
    for (int k = 2; k <= LERP_LAT; k++) begin
      side[k] <= side[k-1];
    end
  end

  tpss_lerp u_l01x (.clk, .u(it.vert_a_x), .v(it.vert_b_x), .uz(it.vert_a_z),
                    .vz(it.vert_b_z), .level(lvl), .res(l01x));
  tpss_lerp u_l01y (.clk, .u(it.vert_a_y), .v(it.vert_b_y), .uz(it.vert_a_z),
                    .vz(it.vert_b_z), .level(lvl), .res(l01y));
  tpss_lerp u_l12x (.clk, .u(it.vert_b_x), .v(it.vert_c_x), .uz(it.vert_b_z),
                    .vz(it.vert_c_z), .level(lvl), .res(l12x));
  tpss_lerp u_l12y (.clk, .u(it.vert_b_y), .v(it.vert_c_y), .uz(it.vert_b_z),
                    .vz(it.vert_c_z), .level(lvl), .res(l12y));
  tpss_lerp u_l20x (.clk, .u(it.vert_c_x), .v(it.vert_a_x), .uz(it.vert_c_z),
                    .vz(it.vert_a_z), .level(lvl), .res(l20x));
  tpss_lerp u_l20y (.clk, .u(it.vert_c_y), .v(it.vert_a_y), .uz(it.vert_c_z),
                    .vz(it.vert_a_z), .level(lvl), .res(l20y));

  side_t sl;
  logic signed [31:0] sx1, sy1, sx2, sy2;

  assign sl = side[LERP_LAT];

  always_comb begin
    case (sl.p1s)
      SRC_V0:  begin sx1 = sl.x0; sy1 = sl.y0; end
      SRC_V1:  begin sx1 = sl.x1; sy1 = sl.y1; end
      SRC_V2:  begin sx1 = sl.x2; sy1 = sl.y2; end
      SRC_L01: begin sx1 = l01x;  sy1 = l01y;  end
      SRC_L12: begin sx1 = l12x;  sy1 = l12y;  end
      SRC_L20: begin sx1 = l20x;  sy1 = l20y;  end
      default: begin sx1 = l20x;  sy1 = l20y;  end
    endcase
    case (sl.p2s)
      SRC_V0:  begin sx2 = sl.x0; sy2 = sl.y0; end
      SRC_V1:  begin sx2 = sl.x1; sy2 = sl.y1; end
      SRC_V2:  begin sx2 = sl.x2; sy2 = sl.y2; end
      SRC_L01: begin sx2 = l01x;  sy2 = l01y;  end
      SRC_L12: begin sx2 = l12x;  sy2 = l12y;  end
      SRC_L20: begin sx2 = l20x;  sy2 = l20y;  end
      default: begin sx2 = l20x;  sy2 = l20y;  end
    endcase
  end

  logic v20, keep20, edge20;
  logic signed [31:0] p1x, p1y, p2x, p2y;
  logic [3:0] nsg20;

  always_ff @(posedge clk) begin
    if (rst) begin
      v20 <= 1'b0;
    end else begin
      v20 <= vld[LERP_LAT];
    end
    keep20 <= sl.keep;
    edge20 <= sl.on_edge;
    nsg20  <= {sl.nxn, sl.nxp, sl.nyn, sl.nyp};
    p1x <= sx1;
    p1y <= sy1;
    p2x <= sx2;
    p2y <= sy2;
  end

  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady, apx, apy, ap1x, ap1y;
  logic [63:0] sq;
  logic is_short;

  assign dx   = 33'(p2x) - 33'(p1x);
  assign dy   = 33'(p2y) - 33'(p1y);
  assign adx  = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady  = dy[32] ? 33'(-dy) : 33'(dy);
  assign apx  = p2x[31] ? 33'(-33'(p2x)) : 33'(p2x);
  assign apy  = p2y[31] ? 33'(-33'(p2y)) : 33'(p2y);
  assign ap1x = p1x[31] ? 33'(-33'(p1x)) : 33'(p1x);
  assign ap1y = p1y[31] ? 33'(-33'(p1y)) : 33'(p1y);
  assign sq   = 64'(adx[SW-1:0]) * 64'(adx[SW-1:0]) + 64'(ady[SW-1:0]) * 64'(ady[SW-1:0]);
  assign is_short = adx <= 33'(SHORT_LIM) && ady <= 33'(SHORT_LIM) &&
                    (sq * 64'd1000000) < (64'd1 << (2 * COORD_FRAC_BITS));

  logic v21, keep21;
  logic [3:0] nsg21;
  logic [49:0] ex, ey;
  logic [32:0] thx, thy;
  logic lx, ly, gx, gy;
  seg_t seg21;

  always_ff @(posedge clk) begin
    if (rst) begin
      v21 <= 1'b0;
    end else begin
      v21 <= v20;
    end
    keep21 <= keep20 && (edge20 || !is_short);
    nsg21  <= nsg20;
    ex  <= 50'(p2x == 0 ? ap1x : adx) * 50'(NEAR_K);
    ey  <= 50'(p2y == 0 ? ap1y : ady) * 50'(NEAR_K);
    thx <= p2x == 0 ? 33'(1 << COORD_FRAC_BITS) : apx;
    thy <= p2y == 0 ? 33'(1 << COORD_FRAC_BITS) : apy;
    lx  <= p1x < p2x;
    ly  <= p1y < p2y;
    gx  <= p2x < p1x;
    gy  <= p2y < p1y;
    seg21 <= '{p1x, p1y, p2x, p2y};
  end

  logic nxn, nxp, nyn, nyp, swp;

  assign {nxn, nxp, nyn, nyp} = nsg21;

  always_comb begin
    if (ex < 50'(thx)) begin
      swp = ly ? nxn : nxp;
    end else if (ey < 50'(thy)) begin
      swp = lx ? nyp : nyn;
    end else if (lx && ly) begin
      swp = nxn;
    end else if (gx && gy) begin
      swp = nxp;
    end else if (lx && gy) begin
      swp = nxp;
    end else begin
      swp = nxn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v21 && keep21;
    end
    if (swp) begin
      result <= '{seg21.seg_end_x, seg21.seg_end_y, seg21.seg_start_x, seg21.seg_start_y};
    end else begin
      result <= seg21;
    end
  end

endmodule

// ===== hw/rtl/tpss_check.sv =====
// Port checker for the triangle plane slicer and its bind to the top level.
`timescale 1ns / 1ps
module tpss_check (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input tpss_pkg::item_t item
);
  import tpss_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("Slicer raised busy.");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, OUT_LAT))
    else $error("Segment word without a facet taken at the pipeline latency.");

  a_flat_no_seg: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.vert_a_z == item.vert_b_z && item.vert_b_z == item.vert_c_z)
    |-> ##OUT_LAT !done)
    else $error("Horizontal facet produced a segment word.");

endmodule

bind triangle_plane_slice_segment tpss_check u_tpss_check (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .item(item)
);

// ===== bench/tb_triangle_plane_slice_segment.sv =====
// Self-checking testbench for the triangle plane slicer, with its own segment predictor.
`timescale 1ns / 1ps
module tb_triangle_plane_slice_segment;
  import tpss_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int N_RANDOM = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic cfg_we = 1'b0;
  logic signed [31:0] cfg_data = '0;
  logic done;
  seg_t result;

  bit row_typed = 1'b0;
  bit row_has = 1'b0;
  seg_t row_seg = '0;

  longint level_model = 0;
  seg_t seg_expected[$];
  int gap_pct = 0;
  int n_err = 0;
  int n_facets = 0;
  int n_segs = 0;
  int n_levels = 0;
  int quiet = 0;

  triangle_plane_slice_segment u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned absv(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic longint crossing(longint u, longint v, longint num, longint den);
    longint du;
    bit [127:0] p, q, r, d;
    bit neg;
    du = u - v;
    if (den == 0 || du == 0 || num == 0) return v;
    d = 128'(absv(den));
    p = 128'(absv(du)) * 128'(absv(num));
    q = p / d;
    r = p % d;
    if (r >= d - r) q = q + 1;
    neg = ((du < 0) != (num < 0)) != (den < 0);
    return neg ? v - longint'(q[63:0]) : v + longint'(q[63:0]);
  endfunction

  function automatic bit spans(longint l, longint z1, longint z2);
    return (z1 <= l && l <= z2) || (z2 <= l && l <= z1);
  endfunction

  function automatic bit too_short(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = absv(dx);
    ay = absv(dy);
    if (ax > 66 || ay > 66) return 1'b0;
    return (ax * ax + ay * ay) * 64'd1000000 < (64'd1 << (2 * COORD_FRAC_BITS));
  endfunction

  function automatic bit near_eq(longint a, longint b);
    if (b != 0) return absv(a - b) * 64'd100000 < absv(b);
    return absv(a) * 64'd100000 < (64'd1 << COORD_FRAC_BITS);
  endfunction

  function automatic bit slice_facet(item_t f, longint lv, output seg_t s);
    longint x[3], y[3], z[3];
    longint nx, ny, p1x, p1y, p2x, p2y, qx, qy, t;
    bit t1, t2, on_edge, swp;
    x[0] = f.vert_a_x; y[0] = f.vert_a_y; z[0] = f.vert_a_z;
    x[1] = f.vert_b_x; y[1] = f.vert_b_y; z[1] = f.vert_b_z;
    x[2] = f.vert_c_x; y[2] = f.vert_c_y; z[2] = f.vert_c_z;
    nx = f.normal_x;
    ny = f.normal_y;
    p1x = 0; p1y = 0; p2x = 0; p2y = 0;
    t1 = 0; t2 = 0; on_edge = 0; swp = 0;
    s = '0;
    if ((lv < z[0] && lv < z[1] && lv < z[2]) || (z[0] < lv && z[1] < lv && z[2] < lv))
      return 0;
    if (z[0] == lv && z[1] == lv && z[2] == lv) return 0;
    if ((z[0] == lv && z[1] == lv && z[2] < lv) || (z[0] == lv && z[2] == lv && z[1] < lv) ||
        (z[1] == lv && z[2] == lv && z[0] < lv))
      return 0;
    if (spans(lv, z[0], z[1])) begin
      if (z[0] == z[1]) begin
        if (y[2] > lv) return 0;
        p1x = x[0]; p1y = y[0]; p2x = x[1]; p2y = y[1];
        on_edge = 1;
      end else begin
        p1x = crossing(x[0], x[1], lv - z[1], z[0] - z[1]);
        p1y = crossing(y[0], y[1], lv - z[1], z[0] - z[1]);
        t1 = 1;
      end
    end
    if (!on_edge && spans(lv, z[1], z[2])) begin
      if (z[1] == z[2]) begin
        if (y[0] > lv) return 0;
        p1x = x[1]; p1y = y[1]; p2x = x[2]; p2y = y[2];
        on_edge = 1;
      end else begin
        qx = crossing(x[1], x[2], lv - z[2], z[1] - z[2]);
        qy = crossing(y[1], y[2], lv - z[2], z[1] - z[2]);
        if (!t1) begin
          p1x = qx; p1y = qy; t1 = 1;
        end else begin
          p2x = qx; p2y = qy; t2 = 1;
        end
      end
    end
    if (!on_edge) begin
      if (!t1) return 0;
      if (!t2 && spans(lv, z[2], z[0])) begin
        p2x = crossing(x[2], x[0], lv - z[0], z[2] - z[0]);
        p2y = crossing(y[2], y[0], lv - z[0], z[2] - z[0]);
        t2 = 1;
      end
      if (!t2) return 0;
      if (too_short(p2x - p1x, p2y - p1y)) return 0;
    end
    if (near_eq(p1x, p2x)) begin
      swp = (p1y < p2y) ? (nx < 0) : (nx > 0);
    end else if (near_eq(p1y, p2y)) begin
      swp = (p1x < p2x) ? (ny > 0) : (ny < 0);
    end else if (p1x < p2x && p1y < p2y) begin
      swp = nx < 0;
    end else if (p2x < p1x && p2y < p1y) begin
      swp = nx > 0;
    end else if (p1x < p2x && p2y < p1y) begin
      swp = nx > 0;
    end else begin
      swp = nx < 0;
    end
    if (swp) begin
      t = p1x; p1x = p2x; p2x = t;
      t = p1y; p1y = p2y; p2y = t;
    end
    s.seg_start_x = p1x[31:0];
    s.seg_start_y = p1y[31:0];
    s.seg_end_x = p2x[31:0];
    s.seg_end_y = p2y[31:0];
    return 1;
  endfunction

  function automatic item_t facet(longint ax, longint ay, longint az, longint bx, longint by,
                                  longint bz, longint cx, longint cy, longint cz,
                                  longint nx, longint ny);
    item_t f;
    f.vert_a_x = ax[31:0]; f.vert_a_y = ay[31:0]; f.vert_a_z = az[31:0];
    f.vert_b_x = bx[31:0]; f.vert_b_y = by[31:0]; f.vert_b_z = bz[31:0];
    f.vert_c_x = cx[31:0]; f.vert_c_y = cy[31:0]; f.vert_c_z = cz[31:0];
    f.normal_x = nx[15:0]; f.normal_y = ny[15:0];
    return f;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint near_coord(longint centre);
    case ($urandom_range(0, 3))
      0: return centre;
      1: return sat32(centre + $signed($urandom_range(0, 8)) - 4);
      2: return sat32(centre + $signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return longint'($signed($urandom));
    endcase
  endfunction

  function automatic item_t random_facet(longint lv);
    item_t f;
    longint v[11];
    if ($urandom_range(0, 9) < 2) begin
      f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      v[3 * i] = ($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
                 : sat32($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      v[3 * i + 1] = ($urandom_range(0, 3) == 0) ? near_coord(lv)
                     : sat32($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      v[3 * i + 2] = near_coord(lv);
    end
    v[9] = $signed($urandom_range(0, 65535)) - 32768;
    v[10] = $signed($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 3) == 0) v[9] = 0;
    if ($urandom_range(0, 3) == 0) v[10] = 0;
    return facet(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10]);
  endfunction

  task automatic report(string what, seg_t e, seg_t a);
    n_err++;
    if (n_err <= 10)
      $display("%0t mismatch %s: expected %h %h %h %h got %h %h %h %h", $realtime, what,
               e.seg_start_x, e.seg_start_y, e.seg_end_x, e.seg_end_y,
               a.seg_start_x, a.seg_start_y, a.seg_end_x, a.seg_end_y);
  endtask

  always @(posedge clk) begin
    seg_t s, e;
    if (!rst) begin
      quiet++;
      if (start && !busy) begin
        quiet = 0;
        n_facets++;
        if (row_typed) begin
          if (row_has) seg_expected.insert(seg_expected.size(), row_seg);
        end else if (slice_facet(item, level_model, s)) begin
          seg_expected.insert(seg_expected.size(), s);
        end
      end
      if (done) begin
        quiet = 0;
        n_segs++;
        if (seg_expected.size() == 0) begin
          report("unexpected segment", '0, result);
        end else begin
          e = seg_expected.pop_front();
          if (result.seg_start_x !== e.seg_start_x) report("seg_start_x", e, result);
          if (result.seg_start_y !== e.seg_start_y) report("seg_start_y", e, result);
          if (result.seg_end_x !== e.seg_end_x) report("seg_end_x", e, result);
          if (result.seg_end_y !== e.seg_end_y) report("seg_end_y", e, result);
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send(item_t f, bit typed, bit has, seg_t s);
    start <= 1'b1;
    item <= f;
    row_typed <= typed;
    row_has <= has;
    row_seg <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (seg_expected.size() != 0) @(posedge clk);
    repeat (OUT_LAT + 3) @(posedge clk);
  endtask

  task automatic set_level(logic signed [31:0] lv);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= lv;
    @(posedge clk);
    cfg_we <= 1'b0;
    level_model = lv;
    n_levels++;
  endtask

  typedef struct {
    item_t f;
    bit typed;
    bit has;
    seg_t s;
  } row_t;

  initial begin
    row_t rows[15];
    seg_t edge_seg;
    logic signed [31:0] levels[6];
    edge_seg = {32'sd0, 32'sd0, 32'sd131072, 32'sd0};
    rows[0] = '{facet(0, 0, 1, 5, 5, 2, 9, 1, 3, 100, 100), 1, 0, '0};
    rows[1] = '{facet(0, 0, -1, 5, 5, -2, 9, 1, -3, 100, 100), 1, 0, '0};
    rows[2] = '{facet(0, 0, 0, 5, 5, 0, 9, 1, 0, 100, 100), 1, 0, '0};
    rows[3] = '{facet(0, 0, 0, 5, 5, 0, 9, 1, -7, 100, 100), 1, 0, '0};
    rows[4] = '{facet(0, 0, 0, 131072, 0, 0, 9, -5, 65536, 0, 0), 1, 1, edge_seg};
    rows[5] = '{facet(0, 0, 0, 131072, 0, 0, 9, 65536, 65536, 0, 0), 1, 0, '0};
    rows[6] = '{facet(9, -3, 65536, 0, 0, 0, 131072, 0, 0, 0, 0), 0, 0, '0};
    rows[7] = '{facet(0, 0, 0, 9, -3, 65536, 131072, 0, 0, 0, 0), 0, 0, '0};
    rows[8] = '{facet(0, 0, -65536, 65536, 65536, 65536, 131072, 0, 65536, 5, -5),
                0, 0, '0};
    rows[9] = '{facet(0, 0, -65536, 65536, 65536, 65536, 131072, 0, 65536, -5, 5),
                0, 0, '0};
    rows[10] = '{facet(0, 0, -65536, 10, 10, 65536, 20, 0, 65536, 1, 1), 0, 0, '0};
    rows[11] = '{facet(0, 0, -65536, 0, 65536, 65536, 65536, 0, 65536, 0, -1),
                 0, 0, '0};
    rows[12] = '{facet(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647,
                       2147483647, -2147483648, 2147483647, 2147483647, -32768, 32767),
                 0, 0, '0};
    rows[13] = '{facet(2147483647, -2147483648, 2147483647, -2147483648, 2147483647,
                       -2147483648, 2147483647, 2147483647, -2147483648, 32767, -32768),
                 0, 0, '0};
    rows[14] = '{facet(-1, -1, -1, -1, -1, 1, -1, -1, 1, -1, -1), 0, 0, '0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].f, rows[i].typed, rows[i].has, rows[i].s);
    levels[0] = 32'sh7fffffff;
    levels[1] = 32'sh80000000;
    levels[2] = 32'sd65536;
    levels[3] = -32'sd98304;
    levels[4] = $urandom;
    levels[5] = 32'sd0;
    for (int ph = 0; ph < 6; ph++) begin
      set_level(levels[ph]);
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 66;
        default: gap_pct = 26;
      endcase
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        if (k == 60) drain();
        send(random_facet(level_model), 0, 0, '0);
      end
    end
    drain();
    $display("Drove %0d facets over %0d plane levels and checked %0d segments.",
             n_facets, n_levels, n_segs);
    if (n_err == 0 && seg_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d segments still expected.", n_err, seg_expected.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
